/* design/rte_pkg.sv */
// ---------------------------------------------------------------------------
// rte_pkg: shared types and constants of the region table engine
// Opcodes, status codes, the slot entry layout and the ring control group.
// ---------------------------------------------------------------------------
package rte_pkg;

    localparam int SLOTS_DEF       = 64;
    localparam int PLACE_TRIES_DEF = 64;

    localparam logic [20:0] SPACE_PAGES = 21'h100000;
    localparam logic [19:0] PLACE_RESET = 20'h60000;

    localparam logic [2:0] OP_CLEAR = 3'd0;
    localparam logic [2:0] OP_QUERY = 3'd1;
    localparam logic [2:0] OP_ADD   = 3'd2;
    localparam logic [2:0] OP_CUT   = 3'd3;
    localparam logic [2:0] OP_PROT  = 3'd4;
    localparam logic [2:0] OP_PLACE = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NOFIT = 2'd2;

    typedef struct packed {
        logic [19:0] start_pg;
        logic [20:0] end_pg;
        logic [2:0]  prot;
        logic [7:0]  flags;
    } region_t;

    typedef struct packed {
        logic    used;
        region_t rg;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic clear;
        logic wr_en;
    } ring_ctl_t;

endpackage

/* design/rte_cell.sv */
// ---------------------------------------------------------------------------
// rte_cell: one slot of the region ring
// Holds one region; clears, takes a direct write, shifts in from its neighbor, or holds.
// ---------------------------------------------------------------------------
module rte_cell
    import rte_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ring_ctl_t ctl,
    input  logic      sel,
    input  entry_t    wr_data,
    input  entry_t    nbr,
    output entry_t    q
);

    logic    used_reg;
    region_t rg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            used_reg <= 1'b0;
        end
        else if (ctl.wr_en && sel)
        begin
            used_reg <= wr_data.used;
        end
        else if (ctl.shift)
        begin
            used_reg <= nbr.used;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en && sel)
        begin
            rg_reg <= wr_data.rg;
        end
        else if (ctl.shift)
        begin
            rg_reg <= nbr.rg;
        end
    end

    assign q = '{used: used_reg, rg: rg_reg};

endmodule

/* design/rte_ctrl.sv */
// ---------------------------------------------------------------------------
// rte_ctrl: sequencer of the region table engine
// Walks the ring head one slot per shift, splits regions, inserts into the
// lowest free slot, runs placement tries and drives the handshakes.
// ---------------------------------------------------------------------------
module rte_ctrl
    import rte_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int PLACE_TRIES = PLACE_TRIES_DEF,
    localparam int IW         = $clog2(SLOTS),
    localparam int TW         = $clog2(PLACE_TRIES + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [2:0]       opcode,
    input  logic [19:0]      start_page,
    input  logic [20:0]      end_page,
    input  logic [20:0]      length_pages,
    input  logic [2:0]       prot,
    input  logic [7:0]       region_flags,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [1:0]       status,
    output logic             overlap,
    output logic [19:0]      placed_page,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [19:0]      cfg_data,
    input  entry_t           head,
    input  logic [SLOTS-1:0] used_vec,
    output ring_ctl_t        ring,
    output logic [IW-1:0]    wr_idx,
    output entry_t           wr_data,
    output entry_t           tail_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_SCAN, S_INS1, S_INS2, S_PCHK, S_PDEC, S_PINS, S_DONE
    } state_t;

    state_t         state_reg;
    logic [2:0]     op_reg;
    logic [20:0]    a_reg;
    logic [20:0]    b_reg;
    logic [20:0]    len_reg;
    logic [2:0]     pr_reg;
    logic [7:0]     fl_reg;
    logic [IW-1:0]  i_reg;
    logic [TW-1:0]  tries_reg;
    logic           hit_reg;
    logic           two_reg;
    entry_t         p1_reg;
    entry_t         p2_reg;
    entry_t         p1_next;
    entry_t         p2_next;
    logic [20:0]    nfp_reg;
    logic [19:0]    base_reg;
    logic [1:0]     res_status_reg;
    logic           res_ovl_reg;
    logic [19:0]    res_placed_reg;
    logic           out_valid_reg;
    logic [1:0]     status_reg;
    logic           overlap_reg;
    logic [19:0]    placed_reg;

    logic           free_lo_found;
    logic           free_hi_found;
    logic [IW-1:0]  free_lo_idx;
    logic [IW-1:0]  free_hi_idx;
    logic [IW-1:0]  ins_idx;
    logic [20:0]    vs;
    logic [20:0]    ve;
    logic           hd_hit;
    logic           full_cov;
    logic           mid;
    logic           left;
    logic           last_slot;
    logic           split_op;
    logic           in_place;
    entry_t         new_entry;

    // lowest free slot: slots below the head sit at the top of the ring
    always_comb
    begin
        free_lo_found = 1'b0;
        free_hi_found = 1'b0;
        free_lo_idx   = '0;
        free_hi_idx   = '0;
        for (int p = SLOTS - 1; p >= 0; p--)
        begin
            if (!used_vec[p])
            begin
                free_lo_found = 1'b1;
                free_lo_idx   = IW'(p);
                if ((p + int'(i_reg)) >= SLOTS)
                begin
                    free_hi_found = 1'b1;
                    free_hi_idx   = IW'(p);
                end
            end
        end
    end

    assign ins_idx = free_hi_found ? free_hi_idx : free_lo_idx;

    assign vs        = {1'b0, head.rg.start_pg};
    assign ve        = head.rg.end_pg;
    assign hd_hit    = head.used && !(b_reg <= vs || a_reg >= ve);
    assign full_cov  = (a_reg <= vs) && (b_reg >= ve);
    assign mid       = (a_reg > vs) && (b_reg < ve);
    assign left      = (a_reg <= vs);
    assign last_slot = (i_reg == IW'(SLOTS - 1));
    assign split_op  = (op_reg == OP_CUT) || (op_reg == OP_PROT);
    assign in_place  = split_op && hd_hit && !full_cov && ((op_reg == OP_PROT) || mid);

    assign new_entry = '{used: 1'b1,
                         rg: '{start_pg: a_reg[19:0], end_pg: b_reg,
                               prot: pr_reg, flags: fl_reg}};

    // pieces split off the head region
    always_comb
    begin
        p1_next = head;
        p2_next = head;
        if (op_reg == OP_CUT)
        begin
            p1_next.rg.start_pg = b_reg[19:0];
        end
        else if (mid)
        begin
            p1_next.rg.start_pg = a_reg[19:0];
            p1_next.rg.end_pg   = b_reg;
            p1_next.rg.prot     = pr_reg;
            p2_next.rg.start_pg = b_reg[19:0];
        end
        else if (left)
        begin
            p1_next.rg.end_pg = b_reg;
            p1_next.rg.prot   = pr_reg;
        end
        else
        begin
            p1_next.rg.start_pg = a_reg[19:0];
            p1_next.rg.prot     = pr_reg;
        end
    end

    always_comb
    begin
        ring      = '0;
        wr_idx    = '0;
        wr_data   = head;
        tail_data = head;
        unique case (state_reg)
            S_EXEC:
            begin
                if (op_reg == OP_CLEAR)
                begin
                    ring.clear = 1'b1;
                end
                if (op_reg == OP_ADD && b_reg <= SPACE_PAGES && free_lo_found)
                begin
                    ring.wr_en = 1'b1;
                    wr_idx     = ins_idx;
                    wr_data    = new_entry;
                end
            end
            S_SCAN:
            begin
                if (in_place)
                begin
                    // trim the head where it stands, pieces follow
                    ring.wr_en = 1'b1;
                    wr_idx     = '0;
                    if (left)
                    begin
                        wr_data.rg.start_pg = b_reg[19:0];
                    end
                    else
                    begin
                        wr_data.rg.end_pg = a_reg;
                    end
                end
                else
                begin
                    ring.shift = 1'b1;
                    if (split_op && hd_hit)
                    begin
                        if (full_cov)
                        begin
                            if (op_reg == OP_CUT)
                            begin
                                tail_data.used = 1'b0;
                            end
                            else
                            begin
                                tail_data.rg.prot = pr_reg;
                            end
                        end
                        else if (left)
                        begin
                            tail_data.rg.start_pg = b_reg[19:0];
                        end
                        else
                        begin
                            tail_data.rg.end_pg = a_reg;
                        end
                    end
                end
            end
            S_INS1:
            begin
                ring.shift = !two_reg;
                wr_data    = p1_reg;
                if (free_lo_found)
                begin
                    ring.wr_en = 1'b1;
                    wr_idx     = two_reg ? ins_idx : ins_idx - IW'(1);
                end
            end
            S_INS2:
            begin
                ring.shift = 1'b1;
                wr_data    = p2_reg;
                if (free_lo_found)
                begin
                    ring.wr_en = 1'b1;
                    wr_idx     = ins_idx - IW'(1);
                end
            end
            S_PINS:
            begin
                if (free_lo_found)
                begin
                    ring.wr_en = 1'b1;
                    wr_idx     = ins_idx;
                    wr_data    = new_entry;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            i_reg          <= '0;
            tries_reg      <= '0;
            hit_reg        <= 1'b0;
            two_reg        <= 1'b0;
            nfp_reg        <= {1'b0, PLACE_RESET};
            base_reg       <= PLACE_RESET;
            out_valid_reg  <= 1'b0;
            op_reg         <= OP_CLEAR;
            res_status_reg <= ST_OK;
            res_ovl_reg    <= 1'b0;
            res_placed_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                base_reg <= cfg_data;
            end
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg         <= opcode;
                        a_reg          <= (opcode == OP_PLACE) ? nfp_reg : {1'b0, start_page};
                        b_reg          <= end_page;
                        len_reg        <= length_pages;
                        pr_reg         <= prot;
                        fl_reg         <= region_flags;
                        res_status_reg <= ST_OK;
                        res_ovl_reg    <= 1'b0;
                        res_placed_reg <= '0;
                        i_reg          <= '0;
                        hit_reg        <= 1'b0;
                        tries_reg      <= '0;
                        state_reg      <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_DONE;
                    case (op_reg) inside
                        OP_CLEAR:
                        begin
                            nfp_reg <= {1'b0, base_reg};
                        end
                        OP_QUERY, OP_CUT, OP_PROT:
                        begin
                            state_reg <= S_SCAN;
                        end
                        OP_ADD:
                        begin
                            if (b_reg > SPACE_PAGES)
                            begin
                                res_status_reg <= ST_NOFIT;
                            end
                            else if (!free_lo_found)
                            begin
                                res_status_reg <= ST_FULL;
                            end
                        end
                        OP_PLACE:
                        begin
                            if (len_reg == '0)
                            begin
                                res_status_reg <= ST_NOFIT;
                            end
                            else
                            begin
                                state_reg <= S_PCHK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_SCAN:
                begin
                    if (in_place)
                    begin
                        two_reg   <= (op_reg == OP_PROT) && mid;
                        p1_reg    <= p1_next;
                        p2_reg    <= p2_next;
                        state_reg <= S_INS1;
                    end
                    else
                    begin
                        hit_reg <= hit_reg | hd_hit;
                        i_reg   <= last_slot ? '0 : i_reg + IW'(1);
                        if (last_slot)
                        begin
                            res_ovl_reg <= (op_reg == OP_QUERY) && (hit_reg | hd_hit);
                            state_reg   <= (op_reg == OP_PLACE) ? S_PDEC : S_DONE;
                        end
                    end
                end
                S_INS1:
                begin
                    if (two_reg)
                    begin
                        state_reg <= S_INS2;
                    end
                    else
                    begin
                        i_reg     <= last_slot ? '0 : i_reg + IW'(1);
                        state_reg <= last_slot ? S_DONE : S_SCAN;
                    end
                end
                S_INS2:
                begin
                    i_reg     <= last_slot ? '0 : i_reg + IW'(1);
                    state_reg <= last_slot ? S_DONE : S_SCAN;
                end
                S_PCHK:
                begin
                    if (a_reg > SPACE_PAGES || len_reg > SPACE_PAGES - a_reg)
                    begin
                        res_status_reg <= ST_NOFIT;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        b_reg     <= a_reg + len_reg;
                        i_reg     <= '0;
                        hit_reg   <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_PDEC:
                begin
                    if (!hit_reg)
                    begin
                        if (b_reg > nfp_reg)
                        begin
                            nfp_reg <= b_reg;
                        end
                        state_reg <= S_PINS;
                    end
                    else if (tries_reg >= TW'(PLACE_TRIES))
                    begin
                        res_status_reg <= ST_NOFIT;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        tries_reg <= tries_reg + TW'(1);
                        a_reg     <= a_reg + len_reg;
                        state_reg <= S_PCHK;
                    end
                end
                S_PINS:
                begin
                    if (free_lo_found)
                    begin
                        res_placed_reg <= a_reg[19:0];
                    end
                    else
                    begin
                        res_status_reg <= ST_FULL;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    // hold the result until the output register frees up
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && (!out_valid_reg || !out_stall))
        begin
            status_reg  <= res_status_reg;
            overlap_reg <= res_ovl_reg;
            placed_reg  <= res_placed_reg;
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign overlap     = overlap_reg;
    assign placed_page = placed_reg;

    a_tail_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ring.wr_en && ring.shift) |-> (wr_idx != IW'(SLOTS - 1)))
        else $error("insert collides with the ring tail");

    a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE || state_reg == S_PDEC) |-> (i_reg == '0))
        else $error("ring not realigned after a pass");

    a_place_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PINS) |-> (b_reg <= SPACE_PAGES && b_reg > a_reg))
        else $error("placed range leaves the address space");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside completion");

endmodule

/* design/region_table_engine_top.sv */
// ---------------------------------------------------------------------------
// region_table_engine_top: fixed table of page regions
// Ring of slot cells plus the sequencer that walks it.
// ---------------------------------------------------------------------------
// One operation at a time. The slots form a ring that rotates one slot per
// cycle, except while a split writes its pieces, past a single compare/split
// unit at its head, and each pass is a full turn so the ring is back in slot
// order afterwards. Clear and add make no pass; query, remove and change
// protection make one pass, and remove and change protection also write the
// pieces of a split (up to two per region); place makes one pass per try.
// The next item is taken as soon as the previous result is in the output
// register.
module region_table_engine_top
    import rte_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int PLACE_TRIES = PLACE_TRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [19:0] start_page,
    input  logic [20:0] end_page,
    input  logic [20:0] length_pages,
    input  logic [2:0]  prot,
    input  logic [7:0]  region_flags,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        overlap,
    output logic [19:0] placed_page,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [19:0] cfg_data
);

    localparam int IW = $clog2(SLOTS);

    entry_t           cell_q [SLOTS];
    logic [SLOTS-1:0] used_vec;
    ring_ctl_t        ring;
    logic [IW-1:0]    wr_idx;
    entry_t           wr_data;
    entry_t           tail_data;

    rte_ctrl #(
        .SLOTS       (SLOTS),
        .PLACE_TRIES (PLACE_TRIES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .start_page   (start_page),
        .end_page     (end_page),
        .length_pages (length_pages),
        .prot         (prot),
        .region_flags (region_flags),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .overlap      (overlap),
        .placed_page  (placed_page),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .head         (cell_q[0]),
        .used_vec     (used_vec),
        .ring         (ring),
        .wr_idx       (wr_idx),
        .wr_data      (wr_data),
        .tail_data    (tail_data)
    );

    for (genvar p = 0; p < SLOTS; p++)
    begin : g_cell
        entry_t nbr;

        if (p == SLOTS - 1)
        begin : g_tail
            assign nbr = tail_data;
        end
        else
        begin : g_body
            assign nbr = cell_q[p + 1];
        end

        rte_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ring),
            .sel     (wr_idx == IW'(p)),
            .wr_data (wr_data),
            .nbr     (nbr),
            .q       (cell_q[p])
        );

        assign used_vec[p] = cell_q[p].used;
    end

endmodule
